### hdl/nrmc_pkg.sv
// Shared types, constants and lookup functions for the RMC sentence parser.
package nrmc_pkg;

   localparam int MAX_SENTENCE_BYTES = 128;
   localparam int FRACTION_DIGITS    = 5;

   localparam int ACC_W   = 32;
   localparam int FRAC_W  = 3;
   localparam int PAIR_W  = 7;
   localparam int LEN_W   = 7;
   localparam int FIELD_W = 4;
   localparam int SCALE_W = 24;

   localparam logic [1:0] KIND_NONE = 2'd0;
   localparam logic [1:0] KIND_GN   = 2'd1;
   localparam logic [1:0] KIND_GP   = 2'd2;

   localparam logic [FIELD_W-1:0] FIELD_TIME     = 4'd0;
   localparam logic [FIELD_W-1:0] FIELD_STATUS   = 4'd1;
   localparam logic [FIELD_W-1:0] FIELD_LAT      = 4'd2;
   localparam logic [FIELD_W-1:0] FIELD_LAT_HEMI = 4'd3;
   localparam logic [FIELD_W-1:0] FIELD_LON      = 4'd4;
   localparam logic [FIELD_W-1:0] FIELD_LON_HEMI = 4'd5;
   localparam logic [FIELD_W-1:0] FIELD_DATE     = 4'd8;
   localparam logic [FIELD_W-1:0] FIELD_DONE     = 4'd9;

   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_POINT = 8'h2E;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   localparam logic [LEN_W-1:0] LEN_MAX     = 7'd127;
   localparam logic [LEN_W-1:0] LEN_SHORT   = 7'd5;
   localparam logic [29:0]      LAT_CAP     = 30'd999999999;
   localparam logic [30:0]      LON_CAP     = 31'h7FFFFFFF;
   localparam logic [11:0]      YEAR_BASE   = 12'd2000;
   localparam logic [PAIR_W-1:0] HOUR_MAX   = 7'd63;
   localparam logic [PAIR_W-1:0] HOUR_MIN   = 7'b1000000;

   typedef struct packed {
      logic                valid;
      logic [FIELD_W-1:0]  field;
      logic [LEN_W-1:0]    length;
      logic [7:0]          first_char;
      logic [ACC_W-1:0]    acc;
      logic [FRAC_W-1:0]   frac;
      logic [PAIR_W-1:0]   pair_a;
      logic [PAIR_W-1:0]   pair_b;
      logic [PAIR_W-1:0]   pair_c;
   } nrmc_commit_type;

   typedef struct packed {
      logic [PAIR_W-1:0] hour;
      logic [PAIR_W-1:0] minute;
      logic [PAIR_W-1:0] second;
      logic [7:0]        status;
      logic [29:0]       lat;
      logic [7:0]        lat_hemi;
      logic [30:0]       lon;
      logic [7:0]        lon_hemi;
      logic [PAIR_W-1:0] day;
      logic [PAIR_W-1:0] month;
      logic [PAIR_W-1:0] yy;
   } nrmc_record_type;

   function automatic logic [7:0] gn_char(input logic [2:0] idx);
      logic [7:0] c;
      unique case (idx)
         3'd0: c = "$";
         3'd1: c = "G";
         3'd2: c = "N";
         3'd3: c = "R";
         3'd4: c = "M";
         3'd5: c = "C";
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] gp_char(input logic [2:0] idx);
      logic [7:0] c;
      unique case (idx)
         3'd0: c = "$";
         3'd1: c = "G";
         3'd2: c = "P";
         3'd3: c = "R";
         3'd4: c = "M";
         3'd5: c = "C";
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [SCALE_W-1:0] pow10(input logic [FRAC_W-1:0] n);
      logic [SCALE_W-1:0] p;
      unique case (n)
         3'd0: p = 24'd1;
         3'd1: p = 24'd10;
         3'd2: p = 24'd100;
         3'd3: p = 24'd1000;
         3'd4: p = 24'd10000;
         3'd5: p = 24'd100000;
         3'd6: p = 24'd1000000;
         3'd7: p = 24'd10000000;
         default: p = 24'd1;
      endcase
      return p;
   endfunction

endpackage

### hdl/nmea_rmc_sentence_parser.sv
// Top level of the RMC sentence parser: byte register, scanner, record store, result register.
// A result word is loaded into the result register when its final byte leaves the byte register.
// Throughput: one byte word per cycle; the byte register holds only when a final
// byte meets a result word that is still stalled in the output register.
// Reset (synchronous): clears sentence state, the kept record (year reads 2000)
// and the zone shift to zero.
module nmea_rmc_sentence_parser #(
   parameter int MAX_SENTENCE_BYTES = nrmc_pkg::MAX_SENTENCE_BYTES,
   parameter int FRACTION_DIGITS    = nrmc_pkg::FRACTION_DIGITS
) (
   input  logic              clock,
   input  logic              reset,

   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic signed [4:0] csr_zone_hour_shift,

   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_char_byte,
   input  logic              req_last_byte,

   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_sentence_kind,
   output logic signed [6:0] rsp_hour,
   output logic [6:0]        rsp_minute,
   output logic [6:0]        rsp_second,
   output logic [7:0]        rsp_fix_status,
   output logic [29:0]       rsp_latitude,
   output logic [7:0]        rsp_lat_hemisphere,
   output logic [30:0]       rsp_longitude,
   output logic [7:0]        rsp_lon_hemisphere,
   output logic [6:0]        rsp_day,
   output logic [6:0]        rsp_month,
   output logic [11:0]       rsp_year
);

   logic [4:0]                zone_ff;

   logic                      s1_valid_ff, s1_valid_in;
   logic [7:0]                s1_char_ff;
   logic                      s1_last_ff;
   logic                      s1_go;
   logic                      req_take;

   nrmc_pkg::nrmc_commit_type commit;
   nrmc_pkg::nrmc_record_type record_in;
   logic [1:0]                kind;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_load;
   logic [1:0]                kind_ff;
   nrmc_pkg::nrmc_record_type rec_ff;
   logic [11:0]               year_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         zone_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         zone_ff <= csr_zone_hour_shift;
      end
   end

   always_comb begin
      s1_go       = s1_valid_ff && (!s1_last_ff || !rsp_valid_ff || !rsp_stall);
      req_stall   = s1_valid_ff && !s1_go;
      req_take    = req_valid && !req_stall;
      s1_valid_in = req_take ? 1'b1 : (s1_go ? 1'b0 : s1_valid_ff);
      rsp_load    = s1_go && s1_last_ff;
      if (rsp_load)        rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
      else                 rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_char_ff <= req_char_byte;
         s1_last_ff <= req_last_byte;
      end
   end

   nrmc_scan #(
      .MAX_SENTENCE_BYTES (MAX_SENTENCE_BYTES),
      .FRACTION_DIGITS    (FRACTION_DIGITS)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .advance   (s1_go),
      .char_byte (s1_char_ff),
      .last_byte (s1_last_ff),
      .commit    (commit),
      .kind      (kind)
   );

   nrmc_store #(
      .FRACTION_DIGITS (FRACTION_DIGITS)
   ) u_store (
      .clock      (clock),
      .reset      (reset),
      .advance    (s1_go),
      .commit     (commit),
      .zone_shift (zone_ff),
      .record_in  (record_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         kind_ff <= kind;
         rec_ff  <= record_in;
         year_ff <= nrmc_pkg::YEAR_BASE + 12'(record_in.yy);
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_sentence_kind  = kind_ff;
   assign rsp_hour           = $signed(rec_ff.hour);
   assign rsp_minute         = rec_ff.minute;
   assign rsp_second         = rec_ff.second;
   assign rsp_fix_status     = rec_ff.status;
   assign rsp_latitude       = rec_ff.lat;
   assign rsp_lat_hemisphere = rec_ff.lat_hemi;
   assign rsp_longitude      = rec_ff.lon;
   assign rsp_lon_hemisphere = rec_ff.lon_hemi;
   assign rsp_day            = rec_ff.day;
   assign rsp_month          = rec_ff.month;
   assign rsp_year           = year_ff;

   a_final_byte_gives_word: assert property (@(posedge clock) disable iff (reset)
      (s1_go && s1_last_ff) |=> rsp_valid)
      else $error("final byte did not produce a result word");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && s1_last_ff && rsp_valid_ff))
      else $error("input stalled without a blocked final byte");

   a_kind_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_sentence_kind != 2'd3))
      else $error("invalid sentence kind");

   a_year_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_year >= 12'd2000) && (rsp_year <= 12'd2099)))
      else $error("year out of range");

endmodule

### hdl/nrmc_scan.sv
// Per-sentence scanner: prefix match, field split and per-field accumulation.
module nrmc_scan #(
   parameter int MAX_SENTENCE_BYTES = nrmc_pkg::MAX_SENTENCE_BYTES,
   parameter int FRACTION_DIGITS    = nrmc_pkg::FRACTION_DIGITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  logic [7:0]                char_byte,
   input  logic                      last_byte,
   output nrmc_pkg::nrmc_commit_type commit,
   output logic [1:0]                kind
);

   localparam int POS_W = $clog2(MAX_SENTENCE_BYTES);
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_SENTENCE_BYTES - 1);
   localparam logic [nrmc_pkg::FRAC_W-1:0] FRAC_MAX = nrmc_pkg::FRAC_W'(FRACTION_DIGITS);

   logic [POS_W-1:0]               pos_ff, pos_in;
   logic [1:0]                     prefix_ff, prefix_in;
   logic [nrmc_pkg::FIELD_W-1:0]   field_ff, field_in;
   logic [nrmc_pkg::LEN_W-1:0]     len_ff, len_in;
   logic [7:0]                     first_ff, first_in;
   logic [nrmc_pkg::ACC_W-1:0]     acc_ff, acc_in;
   logic [nrmc_pkg::FRAC_W-1:0]    frac_ff, frac_in;
   logic                           point_ff, point_in;
   logic [nrmc_pkg::PAIR_W-1:0]    pa_ff, pa_in, pb_ff, pb_in, pc_ff, pc_in;

   logic                           is_digit;
   logic [3:0]                     digit;
   logic [nrmc_pkg::ACC_W+3:0]     acc_x10;
   logic [nrmc_pkg::ACC_W-1:0]     acc_step;
   logic [1:0]                     prefix_next;
   logic                           parse;
   logic                           head;

   function automatic logic [nrmc_pkg::PAIR_W-1:0] pair_step(
      input logic [nrmc_pkg::PAIR_W-1:0] p, input logic [3:0] d);
      return nrmc_pkg::PAIR_W'({p, 3'b000}) + nrmc_pkg::PAIR_W'({p, 1'b0})
             + nrmc_pkg::PAIR_W'(d);
   endfunction

   always_comb begin
      is_digit = (char_byte >= nrmc_pkg::CHAR_ZERO) && (char_byte <= nrmc_pkg::CHAR_NINE);
      digit    = is_digit ? 4'(char_byte - nrmc_pkg::CHAR_ZERO) : 4'd0;
      acc_x10  = {acc_ff, 3'b000} + {2'b00, acc_ff, 1'b0} + (nrmc_pkg::ACC_W+4)'(digit);
      acc_step = (|acc_x10[nrmc_pkg::ACC_W+3:nrmc_pkg::ACC_W]) ? '1
                 : acc_x10[nrmc_pkg::ACC_W-1:0];

      head        = pos_ff < POS_W'(6);
      prefix_next = (pos_ff == '0) ? 2'b11 : prefix_ff;
      if (head) begin
         if (char_byte != nrmc_pkg::gn_char(pos_ff[2:0])) prefix_next[0] = 1'b0;
         if (char_byte != nrmc_pkg::gp_char(pos_ff[2:0])) prefix_next[1] = 1'b0;
      end

      kind = nrmc_pkg::KIND_NONE;
      if (pos_ff >= POS_W'(5)) begin
         if (prefix_next[0])      kind = nrmc_pkg::KIND_GN;
         else if (prefix_next[1]) kind = nrmc_pkg::KIND_GP;
      end

      parse = (pos_ff >= POS_W'(7)) && (prefix_ff != 2'b00)
              && (field_ff < nrmc_pkg::FIELD_DONE);

      commit.valid      = parse && (char_byte == nrmc_pkg::CHAR_COMMA);
      commit.field      = field_ff;
      commit.length     = len_ff;
      commit.first_char = first_ff;
      commit.acc        = acc_ff;
      commit.frac       = frac_ff;
      commit.pair_a     = pa_ff;
      commit.pair_b     = pb_ff;
      commit.pair_c     = pc_ff;

      pos_in    = (pos_ff < POS_LAST) ? pos_ff + POS_W'(1) : pos_ff;
      prefix_in = prefix_next;
      field_in  = field_ff;
      len_in    = len_ff;
      first_in  = first_ff;
      acc_in    = acc_ff;
      frac_in   = frac_ff;
      point_in  = point_ff;
      pa_in     = pa_ff;
      pb_in     = pb_ff;
      pc_in     = pc_ff;

      if (parse) begin
         if (char_byte == nrmc_pkg::CHAR_COMMA) begin
            field_in = field_ff + nrmc_pkg::FIELD_W'(1);
            len_in   = '0;
            first_in = '0;
            acc_in   = '0;
            frac_in  = '0;
            point_in = 1'b0;
            pa_in    = '0;
            pb_in    = '0;
            pc_in    = '0;
         end else begin
            if (len_ff == '0) first_in = char_byte;
            if (len_ff < nrmc_pkg::LEN_W'(2))      pa_in = pair_step(pa_ff, digit);
            else if (len_ff < nrmc_pkg::LEN_W'(4)) pb_in = pair_step(pb_ff, digit);
            else if (len_ff < nrmc_pkg::LEN_W'(6)) pc_in = pair_step(pc_ff, digit);
            if (is_digit) begin
               if (!point_ff) begin
                  acc_in = acc_step;
               end else if (frac_ff < FRAC_MAX) begin
                  acc_in  = acc_step;
                  frac_in = frac_ff + nrmc_pkg::FRAC_W'(1);
               end
            end else if (char_byte == nrmc_pkg::CHAR_POINT) begin
               point_in = 1'b1;
            end
            if (len_ff < nrmc_pkg::LEN_MAX) len_in = len_ff + nrmc_pkg::LEN_W'(1);
         end
      end

      if (last_byte) begin
         pos_in    = '0;
         prefix_in = '0;
         field_in  = '0;
         len_in    = '0;
         first_in  = '0;
         acc_in    = '0;
         frac_in   = '0;
         point_in  = 1'b0;
         pa_in     = '0;
         pb_in     = '0;
         pc_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         prefix_ff <= '0;
         field_ff  <= '0;
         len_ff    <= '0;
         first_ff  <= '0;
         acc_ff    <= '0;
         frac_ff   <= '0;
         point_ff  <= 1'b0;
         pa_ff     <= '0;
         pb_ff     <= '0;
         pc_ff     <= '0;
      end else if (advance) begin
         pos_ff    <= pos_in;
         prefix_ff <= prefix_in;
         field_ff  <= field_in;
         len_ff    <= len_in;
         first_ff  <= first_in;
         acc_ff    <= acc_in;
         frac_ff   <= frac_in;
         point_ff  <= point_in;
         pa_ff     <= pa_in;
         pb_ff     <= pb_in;
         pc_ff     <= pc_in;
      end
   end

endmodule

### hdl/nrmc_store.sv
// Kept navigation record: decodes closed fields and updates the stored values.
module nrmc_store #(
   parameter int FRACTION_DIGITS = nrmc_pkg::FRACTION_DIGITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  nrmc_pkg::nrmc_commit_type commit,
   input  logic [4:0]                zone_shift,
   output nrmc_pkg::nrmc_record_type record_in
);

   localparam int PROD_W = nrmc_pkg::ACC_W + nrmc_pkg::SCALE_W;

   nrmc_pkg::nrmc_record_type    kept_ff;

   logic [nrmc_pkg::FRAC_W-1:0]  exponent;
   logic [PROD_W-1:0]            product;
   logic [29:0]                  lat_value;
   logic [30:0]                  lon_value;
   logic [7:0]                   hour_sum;
   logic [nrmc_pkg::PAIR_W-1:0]  hour_value;
   logic [nrmc_pkg::PAIR_W-1:0]  last_pair;
   logic                         long_enough;
   logic                         not_empty;

   always_comb begin
      exponent  = nrmc_pkg::FRAC_W'(FRACTION_DIGITS) - commit.frac;
      product   = PROD_W'(commit.acc) * PROD_W'(nrmc_pkg::pow10(exponent));
      lat_value = (product > PROD_W'(nrmc_pkg::LAT_CAP)) ? nrmc_pkg::LAT_CAP : product[29:0];
      lon_value = (product > PROD_W'(nrmc_pkg::LON_CAP)) ? nrmc_pkg::LON_CAP : product[30:0];

      hour_sum = {1'b0, commit.pair_a} + {{3{zone_shift[4]}}, zone_shift};
      if ($signed(hour_sum) > $signed(8'sd63))       hour_value = nrmc_pkg::HOUR_MAX;
      else if ($signed(hour_sum) < $signed(-8'sd64)) hour_value = nrmc_pkg::HOUR_MIN;
      else                                           hour_value = hour_sum[6:0];

      last_pair = (commit.length == nrmc_pkg::LEN_SHORT)
                  ? nrmc_pkg::PAIR_W'({commit.pair_c, 3'b000})
                    + nrmc_pkg::PAIR_W'({commit.pair_c, 1'b0})
                  : commit.pair_c;

      long_enough = commit.length >= nrmc_pkg::LEN_SHORT;
      not_empty   = commit.length != '0;

      record_in = kept_ff;
      if (advance && commit.valid) begin
         unique case (commit.field)
            nrmc_pkg::FIELD_TIME: begin
               if (long_enough) begin
                  record_in.hour   = hour_value;
                  record_in.minute = commit.pair_b;
                  record_in.second = last_pair;
               end
            end
            nrmc_pkg::FIELD_STATUS: begin
               if (not_empty) record_in.status = commit.first_char;
            end
            nrmc_pkg::FIELD_LAT: begin
               if (not_empty) record_in.lat = lat_value;
            end
            nrmc_pkg::FIELD_LAT_HEMI: begin
               if (not_empty) record_in.lat_hemi = commit.first_char;
            end
            nrmc_pkg::FIELD_LON: begin
               if (not_empty) record_in.lon = lon_value;
            end
            nrmc_pkg::FIELD_LON_HEMI: begin
               if (not_empty) record_in.lon_hemi = commit.first_char;
            end
            nrmc_pkg::FIELD_DATE: begin
               if (long_enough) begin
                  record_in.day   = commit.pair_a;
                  record_in.month = commit.pair_b;
                  record_in.yy    = last_pair;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kept_ff <= '0;
      end else begin
         kept_ff <= record_in;
      end
   end

endmodule
